// ===== rtl/fuzzy_pid_gain_delta_core_assert.svh =====
// ----------------------------------------------------------------------------
// fuzzy_pid_gain_delta_core_assert
// Assertion macros used by the fuzzy PID gain-delta core.
// ----------------------------------------------------------------------------
`ifndef FUZZY_PID_GAIN_DELTA_CORE_ASSERT_SVH
`define FUZZY_PID_GAIN_DELTA_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FPGD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Fixed-latency implication, disabled during reset.
`define FPGD_ASSERT_LAT(lbl, clk, rst, ante, lat, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##lat (cons)) \
      else $error("latency assertion failed");

`endif

// ===== rtl/fpgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpgd_pkg
// Types, breakpoints, rule tables and helpers of the fuzzy PID gain-delta core.
// ----------------------------------------------------------------------------
package fpgd_pkg;

   localparam int TERMS = 7;
   localparam int MU_W  = 13;

   typedef logic [MU_W-1:0]     mu_type;
   typedef mu_type [TERMS-1:0]  mu_vec_type;
   typedef logic [2:0]          term_idx_type;
   typedef logic [2:0]          code_type;

   typedef struct packed {
      logic         valid;
      term_idx_type row;
      term_idx_type col;
      mu_type       w;
   } sel_type;

   localparam mu_type ONE_Q12 = 13'd4096;

   // membership shape codes
   localparam logic [1:0] KIND_Z = 2'd0;
   localparam logic [1:0] KIND_T = 2'd1;
   localparam logic [1:0] KIND_S = 2'd2;

   // linguistic term codes
   localparam code_type CODE_NB = 3'd0;
   localparam code_type CODE_NM = 3'd1;
   localparam code_type CODE_NS = 3'd2;
   localparam code_type CODE_ZO = 3'd3;
   localparam code_type CODE_PS = 3'd4;
   localparam code_type CODE_PM = 3'd5;
   localparam code_type CODE_PB = 3'd6;

   // rule table selectors
   localparam int TBL_P = 0;
   localparam int TBL_I = 1;
   localparam int TBL_D = 2;

   // reciprocal constants for the rounding divides
   localparam logic [17:0] MUL_DIV5  = 18'd52429;   // 2^18 / 5
   localparam logic [17:0] MUL_I     = 18'd134217;  // 2^24 / 125
   localparam logic [17:0] MUL_D     = 18'd209715;  // 2^20 / 5
   localparam logic [6:0]  DIV_I     = 7'd125;
   localparam logic [2:0]  DIV_D     = 3'd5;

   localparam logic [1:0] SHAPE [TERMS] =
      '{KIND_Z, KIND_T, KIND_T, KIND_T, KIND_T, KIND_T, KIND_S};

   localparam logic signed [11:0] ERR_A [TERMS] =
      '{-12'sd1536, -12'sd1536, -12'sd1536, -12'sd1024, -12'sd512, 12'sd0, 12'sd512};
   localparam logic signed [11:0] ERR_B [TERMS] =
      '{-12'sd512, -12'sd1024, -12'sd512, 12'sd0, 12'sd512, 12'sd1024, 12'sd1536};
   localparam logic signed [11:0] ERR_C [TERMS] =
      '{12'sd0, 12'sd0, 12'sd512, 12'sd1024, 12'sd1536, 12'sd1536, 12'sd0};
   localparam logic [3:0] ERR_UP [TERMS] = '{4'd10, 4'd9, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10};
   localparam logic [3:0] ERR_DN [TERMS] = '{4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd9, 4'd10};

   localparam logic signed [11:0] RATE_A [TERMS] =
      '{-12'sd960, -12'sd960, -12'sd960, -12'sd640, -12'sd320, 12'sd0, 12'sd320};
   localparam logic signed [11:0] RATE_B [TERMS] =
      '{-12'sd320, -12'sd640, -12'sd320, 12'sd0, 12'sd320, 12'sd640, 12'sd960};
   localparam logic signed [11:0] RATE_C [TERMS] =
      '{12'sd0, 12'sd0, 12'sd320, 12'sd640, 12'sd960, 12'sd960, 12'sd0};
   localparam logic [3:0] RATE_UP [TERMS] = '{4'd7, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7};
   localparam logic [3:0] RATE_DN [TERMS] = '{4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd6, 4'd7};

   // P, I and D tables, indexed [error term][rate term]
   localparam code_type RULES [3][TERMS][TERMS] = '{
      '{'{CODE_PB, CODE_PB, CODE_PM, CODE_PM, CODE_PS, CODE_ZO, CODE_ZO},
        '{CODE_PB, CODE_PB, CODE_PM, CODE_PS, CODE_PS, CODE_ZO, CODE_NS},
        '{CODE_PM, CODE_PM, CODE_PM, CODE_PS, CODE_ZO, CODE_NS, CODE_NS},
        '{CODE_PM, CODE_PM, CODE_PS, CODE_ZO, CODE_NS, CODE_NM, CODE_NM},
        '{CODE_PS, CODE_PS, CODE_ZO, CODE_NS, CODE_NS, CODE_NM, CODE_NM},
        '{CODE_PS, CODE_ZO, CODE_NS, CODE_NM, CODE_NM, CODE_NM, CODE_NB},
        '{CODE_ZO, CODE_ZO, CODE_NM, CODE_NM, CODE_NM, CODE_NB, CODE_NB}},
      '{'{CODE_NB, CODE_NB, CODE_NM, CODE_NM, CODE_NS, CODE_ZO, CODE_ZO},
        '{CODE_NB, CODE_NB, CODE_NM, CODE_NS, CODE_NS, CODE_ZO, CODE_ZO},
        '{CODE_NB, CODE_NM, CODE_NS, CODE_NS, CODE_ZO, CODE_PS, CODE_PS},
        '{CODE_NM, CODE_NM, CODE_NS, CODE_ZO, CODE_PS, CODE_PM, CODE_PM},
        '{CODE_NM, CODE_NS, CODE_ZO, CODE_PS, CODE_PS, CODE_PM, CODE_PB},
        '{CODE_ZO, CODE_ZO, CODE_PS, CODE_PS, CODE_PM, CODE_PB, CODE_PB},
        '{CODE_ZO, CODE_ZO, CODE_PS, CODE_PM, CODE_PM, CODE_PB, CODE_PB}},
      '{'{CODE_PS, CODE_NS, CODE_NB, CODE_NB, CODE_NB, CODE_NM, CODE_PS},
        '{CODE_PS, CODE_NS, CODE_NB, CODE_NM, CODE_NM, CODE_NS, CODE_ZO},
        '{CODE_ZO, CODE_NS, CODE_NM, CODE_NM, CODE_NS, CODE_NS, CODE_ZO},
        '{CODE_ZO, CODE_NS, CODE_NS, CODE_NS, CODE_NS, CODE_NS, CODE_ZO},
        '{CODE_ZO, CODE_ZO, CODE_ZO, CODE_ZO, CODE_ZO, CODE_ZO, CODE_ZO},
        '{CODE_PB, CODE_NS, CODE_PS, CODE_PS, CODE_PS, CODE_PS, CODE_PB},
        '{CODE_PB, CODE_PM, CODE_PM, CODE_PM, CODE_PS, CODE_PS, CODE_PB}}};

   // Membership of one term in Q1.12; spans are 2^sh or 5 * 2^sh.
   function automatic mu_type fuzz_term(input logic signed [11:0] x,
                                        input logic [1:0] kind,
                                        input logic signed [11:0] a,
                                        input logic signed [11:0] b,
                                        input logic signed [11:0] c,
                                        input logic [3:0] sh_up,
                                        input logic [3:0] sh_dn,
                                        input logic dv5);
      logic signed [12:0] xs, pa, pb, pc;
      logic [12:0] offs;
      logic [3:0]  sh;
      logic [15:0] v;
      logic [31:0] prod;
      logic        sat_one, zero;
      mu_type      m;
      xs = {x[11], x};
      pa = {a[11], a};
      pb = {b[11], b};
      pc = {c[11], c};
      offs = '0;
      sh = sh_up;
      sat_one = 1'b0;
      zero = 1'b0;
      unique case (kind)
         KIND_Z: begin
            if (xs <= pa) begin
               sat_one = 1'b1;
            end else if (xs <= pb) begin
               offs = 13'(pb - xs);
               sh = sh_dn;
            end else begin
               zero = 1'b1;
            end
         end
         KIND_S: begin
            if (xs <= pa) begin
               zero = 1'b1;
            end else if (xs < pb) begin
               offs = 13'(xs - pa);
            end else begin
               sat_one = 1'b1;
            end
         end
         default: begin
            if (xs <= pa) begin
               zero = 1'b1;
            end else if (xs <= pb) begin
               offs = 13'(xs - pa);
            end else if (xs <= pc) begin
               offs = 13'(pc - xs);
               sh = sh_dn;
            end else begin
               zero = 1'b1;
            end
         end
      endcase
      v = 16'(offs) << (4'd12 - sh);
      prod = 32'(v) * 32'(MUL_DIV5);
      if (sat_one) begin
         m = ONE_Q12;
      end else if (zero) begin
         m = '0;
      end else if (dv5) begin
         m = prod[30:18];
      end else begin
         m = v[12:0];
      end
      return m;
   endfunction

   // Twice the term value in base units, scaled by 4096.
   function automatic logic signed [15:0] term_value(input code_type code, input mu_type w);
      logic signed [15:0] ws;
      ws = 16'(w);
      unique case (code)
         CODE_NB: return -16'sd8192 - (ws <<< 2);
         CODE_NM: return -16'sd12288 - ws;
         CODE_NS: return -16'sd8192;
         CODE_ZO: return 16'sd0;
         CODE_PS: return 16'sd8192;
         CODE_PM: return 16'sd12288 + ws;
         CODE_PB: return 16'sd8192 + (ws <<< 2);
         default: return 16'sd0;
      endcase
   endfunction

endpackage

// ===== rtl/fuzzy_pid_gain_delta_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_pid_gain_delta_core
// Fuzzy 7x7 rule-table gain deltas for a self-tuning PID, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  request   start, busy, req_error, req_err_change  start high while busy low
//  response  rsp_valid, rsp_delta_*, rsp_win_strength one-cycle strobe
//
//  One request may start every cycle; busy is always low.
//  Pipeline stages: fuzzify, row scan, row select, lookup and
//  reciprocal multiply, quotient correction.
//  Synchronous reset clears the valid pipe; results in flight are dropped.
//  The receiver takes each result in its strobe cycle, so nothing stalls.
// ----------------------------------------------------------------------------
`include "fuzzy_pid_gain_delta_core_assert.svh"

module fuzzy_pid_gain_delta_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [11:0] req_error,
   input  logic signed [11:0] req_err_change,
   output logic               rsp_valid,
   output logic signed [14:0] rsp_delta_p,
   output logic signed [15:0] rsp_delta_i,
   output logic signed [15:0] rsp_delta_d,
   output logic [12:0]        rsp_win_strength
);
   import fpgd_pkg::*;

   logic       fz_valid;
   mu_vec_type mu_err, mu_rate;
   sel_type    sel;

   assign busy = 1'b0;

   fpgd_fuzz u_fuzz (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start & ~busy),
      .error      (req_error),
      .err_change (req_err_change),
      .out_valid  (fz_valid),
      .mu_err     (mu_err),
      .mu_rate    (mu_rate)
   );

   fpgd_rule_sel u_rule_sel (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fz_valid),
      .mu_err   (mu_err),
      .mu_rate  (mu_rate),
      .sel      (sel)
   );

   fpgd_defuzz u_defuzz (
      .clock        (clock),
      .reset        (reset),
      .sel          (sel),
      .out_valid    (rsp_valid),
      .delta_p      (rsp_delta_p),
      .delta_i      (rsp_delta_i),
      .delta_d      (rsp_delta_d),
      .win_strength (rsp_win_strength)
   );

   `FPGD_ASSERT_LAT(a_latency, clock, reset, start && !busy, 5, rsp_valid)
   `FPGD_ASSERT_NOW(a_strength, clock, reset, rsp_valid, rsp_win_strength <= 13'd4096)
   `FPGD_ASSERT_NOW(a_sel_row, clock, reset, sel.valid, sel.row < 3'd7 && sel.col < 3'd7)
   `FPGD_ASSERT_NOW(a_dp_range, clock, reset, rsp_valid,
                    rsp_delta_p <= 15'sd12288 && rsp_delta_p >= -15'sd12288)
endmodule

// ===== rtl/fpgd_fuzz.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpgd_fuzz
// First stage: fuzzify error and rate into seven memberships each.
// ----------------------------------------------------------------------------
module fpgd_fuzz (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [11:0]       error,
   input  logic signed [11:0]       err_change,
   output logic                     out_valid,
   output fpgd_pkg::mu_vec_type     mu_err,
   output fpgd_pkg::mu_vec_type     mu_rate
);
   import fpgd_pkg::*;

   logic       valid_ff;
   mu_vec_type mu_err_in, mu_err_ff, mu_rate_in, mu_rate_ff;

   // evaluate every term of both inputs
   always_comb begin
      for (int k = 0; k < TERMS; k++) begin
         mu_err_in[k]  = fuzz_term(error, SHAPE[k], ERR_A[k], ERR_B[k], ERR_C[k],
                                   ERR_UP[k], ERR_DN[k], 1'b0);
         mu_rate_in[k] = fuzz_term(err_change, SHAPE[k], RATE_A[k], RATE_B[k], RATE_C[k],
                                   RATE_UP[k], RATE_DN[k], 1'b1);
      end
   end

   // advance valid, load memberships
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      mu_err_ff  <= mu_err_in;
      mu_rate_ff <= mu_rate_in;
   end

   assign out_valid = valid_ff;
   assign mu_err    = mu_err_ff;
   assign mu_rate   = mu_rate_ff;
endmodule

// ===== rtl/fpgd_rule_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpgd_rule_sel
// Two stages: per-row strongest rule, then first strongest row.
// ----------------------------------------------------------------------------
module fpgd_rule_sel (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  fpgd_pkg::mu_vec_type     mu_err,
   input  fpgd_pkg::mu_vec_type     mu_rate,
   output fpgd_pkg::sel_type        sel
);
   import fpgd_pkg::*;

   logic         row_valid_ff;
   mu_type       row_val_in [TERMS];
   mu_type       row_val_ff [TERMS];
   term_idx_type row_col_in [TERMS];
   term_idx_type row_col_ff [TERMS];
   sel_type      sel_in, sel_ff;

   // scan each row from the first column, strict greater wins
   always_comb begin
      mu_type m;
      for (int i = 0; i < TERMS; i++) begin
         row_val_in[i] = (mu_err[i] < mu_rate[0]) ? mu_err[i] : mu_rate[0];
         row_col_in[i] = '0;
         for (int j = 1; j < TERMS; j++) begin
            m = (mu_err[i] < mu_rate[j]) ? mu_err[i] : mu_rate[j];
            if (m > row_val_in[i]) begin
               row_val_in[i] = m;
               row_col_in[i] = 3'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      row_val_ff <= row_val_in;
      row_col_ff <= row_col_in;
   end

   // scan rows in order, earliest row keeps ties
   always_comb begin
      sel_in.valid = row_valid_ff;
      sel_in.w     = row_val_ff[0];
      sel_in.row   = '0;
      sel_in.col   = row_col_ff[0];
      for (int i = 1; i < TERMS; i++) begin
         if (row_val_ff[i] > sel_in.w) begin
            sel_in.w   = row_val_ff[i];
            sel_in.row = 3'(i);
            sel_in.col = row_col_ff[i];
         end
      end
   end

   // load the selection, clear only its valid bit on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff.valid <= 1'b0;
      end else begin
         sel_ff.valid <= sel_in.valid;
      end
      sel_ff.w   <= sel_in.w;
      sel_ff.row <= sel_in.row;
      sel_ff.col <= sel_in.col;
   end

   assign sel = sel_ff;
endmodule

// ===== rtl/fpgd_defuzz.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpgd_defuzz
// Two stages: rule lookup and reciprocal multiply, then correct and sign.
// ----------------------------------------------------------------------------
module fpgd_defuzz (
   input  logic                     clock,
   input  logic                     reset,
   input  fpgd_pkg::sel_type        sel,
   output logic                     out_valid,
   output logic signed [14:0]       delta_p,
   output logic signed [15:0]       delta_i,
   output logic signed [15:0]       delta_d,
   output logic [12:0]              win_strength
);
   import fpgd_pkg::*;

   logic signed [15:0] tp, ti, td;
   logic [14:0]        ap, ai, ad;
   logic [39:0]        prod_i;
   logic [34:0]        prod_d;

   logic        valid_ff;
   logic [2:0]  neg_in, neg_ff;
   logic [13:0] pmag_in, pmag_ff;
   logic [21:0] xi_in, xi_ff;
   logic [14:0] qi_in, qi_ff;
   logic [16:0] xd_in, xd_ff;
   logic [14:0] qd_in, qd_ff;
   mu_type      w_ff;

   logic [21:0] ri;
   logic [16:0] rd;
   logic [14:0] qi_fix, qd_fix;

   logic               rsp_valid_ff;
   logic signed [14:0] dp_ff;
   logic signed [15:0] di_ff, dd_ff;
   mu_type             ws_ff;

   // look up terms and take magnitudes
   always_comb begin
      tp = term_value(RULES[TBL_P][sel.row][sel.col], sel.w);
      ti = term_value(RULES[TBL_I][sel.row][sel.col], sel.w);
      td = term_value(RULES[TBL_D][sel.row][sel.col], sel.w);
      ap = tp[15] ? 15'(-tp) : tp[14:0];
      ai = ti[15] ? 15'(-ti) : ti[14:0];
      ad = td[15] ? 15'(-td) : td[14:0];
      neg_in  = {td[15], ti[15], tp[15]};
      pmag_in = 14'((16'(ap) + 16'd1) >> 1);
      xi_in   = {ai, 7'd0} + 22'd62;
      prod_i  = 40'(xi_in) * 40'(MUL_I);
      qi_in   = prod_i[38:24];
      xd_in   = {ad, 2'd0} + 17'd2;
      prod_d  = 35'(xd_in) * 35'(MUL_D);
      qd_in   = prod_d[34:20];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sel.valid;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      pmag_ff <= pmag_in;
      xi_ff   <= xi_in;
      qi_ff   <= qi_in;
      xd_ff   <= xd_in;
      qd_ff   <= qd_in;
      w_ff    <= sel.w;
   end

   // correct the quotient estimates by one step
   always_comb begin
      ri = xi_ff - 22'(qi_ff) * 22'(DIV_I);
      rd = xd_ff - 17'(qd_ff) * 17'(DIV_D);
      qi_fix = (ri >= 22'(DIV_I)) ? qi_ff + 15'd1 : qi_ff;
      qd_fix = (rd >= 17'(DIV_D)) ? qd_ff + 15'd1 : qd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
   end

   // apply signs, hold result for one cycle
   always_ff @(posedge clock) begin
      dp_ff <= neg_ff[0] ? -$signed({1'b0, pmag_ff}) : $signed({1'b0, pmag_ff});
      di_ff <= neg_ff[1] ? -$signed({1'b0, qi_fix}) : $signed({1'b0, qi_fix});
      dd_ff <= neg_ff[2] ? -$signed({1'b0, qd_fix}) : $signed({1'b0, qd_fix});
      ws_ff <= w_ff;
   end

   assign out_valid    = rsp_valid_ff;
   assign delta_p      = dp_ff;
   assign delta_i      = di_ff;
   assign delta_d      = dd_ff;
   assign win_strength = ws_ff;
endmodule

// ===== tb/tb_fuzzy_pid_gain_delta_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuzzy_pid_gain_delta_core
// Self-checking bench for the fuzzy PID gain-delta core. An in-bench model
// fuzzifies each error / rate pair, picks the winning rule and predicts the
// three gain deltas; a monitor compares every response strobe in order.
// ----------------------------------------------------------------------------
module tb_fuzzy_pid_gain_delta_core;
   import fpgd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 821;
   localparam int PAUSE_AT       = 700;

   typedef struct packed {
      logic signed [11:0] err;
      logic signed [11:0] rate;
   } sample_type;

   typedef struct packed {
      logic signed [14:0] dp;
      logic signed [15:0] di;
      logic signed [15:0] dd;
      logic [12:0]        ws;
   } gains_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [11:0] req_error;
   logic signed [11:0] req_err_change;
   logic               rsp_valid;
   logic signed [14:0] rsp_delta_p;
   logic signed [15:0] rsp_delta_i;
   logic signed [15:0] rsp_delta_d;
   logic [12:0]        rsp_win_strength;

   sample_type pending_q[$];
   gains_type  expected_q[$];
   gains_type  exp_item;
   int         fail_count    = 0;
   int         idle_cycles   = 0;
   int         sent_count    = 0;
   int         checked_count = 0;
   int         total_items   = 0;
   int         burst_left    = 0;
   int         gap_left      = 0;
   bit         hold_off      = 1'b0;
   bit         pause_done    = 1'b0;
   bit         drive_now;

   // breakpoints: a, b, c per term
   const int err_bp [TERMS][3] = '{
      '{-1536, -512, 0}, '{-1536, -1024, 0}, '{-1536, -512, 512},
      '{-1024, 0, 1024}, '{-512, 512, 1536}, '{0, 1024, 1536}, '{512, 1536, 0}};
   const int rate_bp [TERMS][3] = '{
      '{-960, -320, 0}, '{-960, -640, 0}, '{-960, -320, 320},
      '{-640, 0, 640}, '{-320, 320, 960}, '{0, 640, 960}, '{320, 960, 0}};

   // corner values around every breakpoint and at the field limits
   int err_pts [$] = '{-2048, -1537, -1536, -1535, -1025, -1024, -1023, -513, -512,
                       -511, -1, 0, 1, 511, 512, 513, 1023, 1024, 1025, 1535, 1536,
                       1537, 2047};
   int rate_pts [$] = '{-2048, -961, -960, -959, -641, -640, -639, -321, -320, -319,
                        -1, 0, 1, 319, 320, 321, 639, 640, 641, 959, 960, 961, 2047};

   fuzzy_pid_gain_delta_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_error        (req_error),
      .req_err_change   (req_err_change),
      .rsp_valid        (rsp_valid),
      .rsp_delta_p      (rsp_delta_p),
      .rsp_delta_i      (rsp_delta_i),
      .rsp_delta_d      (rsp_delta_d),
      .rsp_win_strength (rsp_win_strength)
   );

   // membership of term k in Q1.12, truncated
   function automatic int fuzz_one(input int x, input int k, input int a, input int b,
                                   input int c);
      int m;
      if (k == 0) begin
         if (x <= a) m = 4096;
         else if (x <= b) m = (b - x) * 4096 / (b - a);
         else m = 0;
      end else if (k == TERMS - 1) begin
         if (x <= a) m = 0;
         else if (x < b) m = (x - a) * 4096 / (b - a);
         else m = 4096;
      end else begin
         if (x <= a) m = 0;
         else if (x <= b) m = (x - a) * 4096 / (b - a);
         else if (x <= c) m = (c - x) * 4096 / (c - b);
         else m = 0;
      end
      return m;
   endfunction

   // twice the term value in base units, times 4096
   function automatic int term_val(input code_type code, input int w);
      int t;
      case (code)
         CODE_NB: t = -8192 - 4 * w;
         CODE_NM: t = -12288 - w;
         CODE_NS: t = -8192;
         CODE_ZO: t = 0;
         CODE_PS: t = 8192;
         CODE_PM: t = 12288 + w;
         CODE_PB: t = 8192 + 4 * w;
         default: t = 0;
      endcase
      return t;
   endfunction

   // divide, rounding halves away from zero
   function automatic int round_div(input int num, input int den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic gains_type predict(input sample_type s);
      int        es [TERMS];
      int        rs [TERMS];
      int        best, m, bi, bj, tp, ti, td;
      gains_type g;
      for (int k = 0; k < TERMS; k++) begin
         es[k] = fuzz_one(int'(s.err), k, err_bp[k][0], err_bp[k][1], err_bp[k][2]);
         rs[k] = fuzz_one(int'(s.rate), k, rate_bp[k][0], rate_bp[k][1], rate_bp[k][2]);
      end
      best = -1;
      bi = 0;
      bj = 0;
      for (int i = 0; i < TERMS; i++) begin
         for (int j = 0; j < TERMS; j++) begin
            m = (es[i] < rs[j]) ? es[i] : rs[j];
            if (m > best) begin
               best = m;
               bi = i;
               bj = j;
            end
         end
      end
      tp = term_val(RULES[TBL_P][bi][bj], best);
      ti = term_val(RULES[TBL_I][bi][bj], best);
      td = term_val(RULES[TBL_D][bi][bj], best);
      g.dp = 15'(round_div(tp, 2));
      g.di = 16'(round_div(ti * 128, 125));
      g.dd = 16'(round_div(td * 4, 5));
      g.ws = 13'(best);
      return g;
   endfunction

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hold reset at the start, then release it
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: retire accepted transfers, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         start          <= 1'b0;
         req_error      <= '0;
         req_err_change <= '0;
      end else begin
         if (start && !busy) begin
            expected_q.push_back(predict(pending_q.pop_front()));
            sent_count++;
         end
         // pause once until every expected result has come
         if (!pause_done && sent_count == PAUSE_AT) hold_off = 1'b1;
         if (hold_off && expected_q.size() == 0) begin
            hold_off   = 1'b0;
            pause_done = 1'b1;
         end
         drive_now = 1'b0;
         if (pending_q.size() != 0 && !hold_off) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = $urandom_range(0, 6);
            end
            if (burst_left > 0) begin
               burst_left--;
               drive_now = 1'b1;
            end else begin
               gap_left--;
            end
         end
         if (start && busy) begin
            // hold the waiting transfer unchanged
            start <= 1'b1;
         end else if (drive_now) begin
            start          <= 1'b1;
            req_error      <= pending_q[0].err;
            req_err_change <= pending_q[0].rate;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each strobe against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("rsp_valid expected 0 actual 1");
            fail_count++;
         end else begin
            exp_item = expected_q.pop_front();
            checked_count++;
            if (rsp_delta_p !== exp_item.dp) begin
               $error("rsp_delta_p expected %0d actual %0d", exp_item.dp, rsp_delta_p);
               fail_count++;
            end
            if (rsp_delta_i !== exp_item.di) begin
               $error("rsp_delta_i expected %0d actual %0d", exp_item.di, rsp_delta_i);
               fail_count++;
            end
            if (rsp_delta_d !== exp_item.dd) begin
               $error("rsp_delta_d expected %0d actual %0d", exp_item.dd, rsp_delta_d);
               fail_count++;
            end
            if (rsp_win_strength !== exp_item.ws) begin
               $error("rsp_win_strength expected %0d actual %0d", exp_item.ws,
                      rsp_win_strength);
               fail_count++;
            end
         end
      end
   end

   // watchdog: end the run after too many cycles without a transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("watchdog expected a transfer actual none for %0d cycles", idle_cycles);
            $display("tb_fuzzy_pid_gain_delta_core: FAIL");
            $finish;
         end
      end
   end

   // build stimulus, wait for the drain, report
   initial begin
      sample_type s;
      foreach (err_pts[i]) begin
         foreach (rate_pts[j]) begin
            s.err  = 12'(err_pts[i]);
            s.rate = 12'(rate_pts[j]);
            pending_q.push_back(s);
         end
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 2 == 0) begin
            s.err  = 12'(int'($urandom_range(0, 3072)) - 1536);
            s.rate = 12'(int'($urandom_range(0, 1920)) - 960);
         end else begin
            s.err  = 12'($urandom);
            s.rate = 12'($urandom);
         end
         pending_q.push_back(s);
      end
      total_items = pending_q.size();
      wait (sent_count == total_items && expected_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d transfers: breakpoint corner grid, in-range and full-range",
               sent_count);
      $display("random pairs, bursty sends and one full drain; %0d results checked",
               checked_count);
      if (fail_count == 0 && checked_count == total_items) begin
         $display("tb_fuzzy_pid_gain_delta_core: PASS");
      end else begin
         $display("tb_fuzzy_pid_gain_delta_core: FAIL");
      end
      $finish;
   end

endmodule

// ===== fuzzy_pid_gain_delta_core.f =====
+incdir+rtl
rtl/fpgd_pkg.sv
rtl/fpgd_fuzz.sv
rtl/fpgd_rule_sel.sv
rtl/fpgd_defuzz.sv
rtl/fuzzy_pid_gain_delta_core.sv
tb/tb_fuzzy_pid_gain_delta_core.sv
